// File: hdl/codebook_4bit_group_dequantizer_assert.svh
// assertion macros for the codebook 4-bit group dequantizer
`ifndef CODEBOOK_4BIT_GROUP_DEQUANTIZER_ASSERT_SVH
`define CODEBOOK_4BIT_GROUP_DEQUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define CBGD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CBGD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CBGD_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define CBGD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/cbgd_pkg.sv
// types and constants shared by the codebook 4-bit group dequantizer
`timescale 1ns / 1ps
package cbgd_pkg;

   localparam int CB_DEPTH         = 16;
   localparam int CB_AW            = 4;
   localparam int NIBBLE_BITS      = 4;
   localparam logic [7:0] NIBBLE_MASK = 8'h0f;

   // transaction kinds on the request channel
   localparam logic [1:0] REQ_CODEBOOK  = 2'd0;
   localparam logic [1:0] REQ_SCALE     = 2'd1;
   localparam logic [1:0] REQ_GROUP_IDX = 2'd2;
   localparam logic [1:0] REQ_DATA      = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_GROUP_LEN     = 2'd0;
   localparam logic [1:0] CSR_SCALE_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_GLOBAL_SCALE  = 2'd2;
   localparam logic [1:0] CSR_ELEMENT_COUNT = 2'd3;

   localparam int CSR_DW = 17;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [9:0]         table_addr;
      logic signed [15:0] code_value;
      logic [15:0]        scale_value;
      logic [7:0]         group_scale_index;
      logic [7:0]         packed_byte;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [15:0]        element_index;
      logic               scale_error;
      logic               last;
      logic               tensor_done;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELEM,
      ST_GRD,
      ST_SRD,
      ST_MUL,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic mul1;
      logic mul2;
      logic emit;
      logic advance;
      logic nib;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_data;
      logic aborted;
      logic final_elem;
      logic out_free;
   } ctrl_status_type;

endpackage

// File: hdl/cbgd_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module cbgd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/cbgd_ctrl.sv
// sequencer for table writes and per-element dequantization steps
`timescale 1ns / 1ps
module cbgd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cbgd_pkg::ctrl_status_type status,
   output cbgd_pkg::ctrl_cmd_type    cmd
);
   import cbgd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           nib_ff, nib_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nib_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         nib_ff   <= nib_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      nib_in    = nib_ff;
      cmd       = '0;
      cmd.nib   = nib_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_data) begin
                  nib_in   = 1'b0;
                  state_in = ST_ELEM;
               end
            end
         end
         ST_ELEM: begin
            if (status.aborted) begin
               // element counted but dropped
               cmd.advance = 1'b1;
               if (status.final_elem || nib_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  nib_in = 1'b1;
               end
            end else begin
               state_in = ST_GRD;
            end
         end
         ST_GRD: state_in = ST_SRD;
         ST_SRD: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul2 = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.advance = 1'b1;
               if (status.final_elem || nib_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  nib_in   = 1'b1;
                  state_in = ST_ELEM;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// File: hdl/cbgd_datapath.sv
// stores, counters, multipliers and output register of the dequantizer
`timescale 1ns / 1ps
`include "codebook_4bit_group_dequantizer_assert.svh"
module cbgd_datapath #(
   parameter int SCALE_DEPTH  = 256,
   parameter int MAX_GROUPS   = 1024,
   parameter int MAX_ELEMENTS = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [1:0]                csr_addr,
   input  logic [16:0]               csr_wdata,
   input  cbgd_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cbgd_pkg::rsp_payload_type rsp_data,
   input  cbgd_pkg::ctrl_cmd_type    cmd,
   output cbgd_pkg::ctrl_status_type status
);
   import cbgd_pkg::*;

   localparam int SAW   = SCALE_DEPTH > 1 ? $clog2(SCALE_DEPTH) : 1;
   localparam int GAW   = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENTS);
   localparam int LIM_W = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;

   // configuration registers
   logic [16:0] group_len_ff;
   logic [8:0]  scale_limit_ff;
   logic [15:0] global_scale_ff;
   logic [16:0] element_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_len_ff     <= 17'd32;
         scale_limit_ff   <= 9'd1;
         global_scale_ff  <= 16'd4096;
         element_count_ff <= 17'd1;
      end else if (csr_write) begin
         case (csr_addr)
            CSR_GROUP_LEN:     group_len_ff     <= csr_wdata;
            CSR_SCALE_LIMIT:   scale_limit_ff   <= csr_wdata[8:0];
            CSR_GLOBAL_SCALE:  global_scale_ff  <= csr_wdata[15:0];
            CSR_ELEMENT_COUNT: element_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table stores
   logic [16:0]       addr_ext;
   logic              cb_we, sc_we, gi_we;
   logic [CB_AW-1:0]  cb_raddr;
   logic [15:0]       cb_rdata, sc_rdata;
   logic [7:0]        gi_rdata;
   logic [GAW-1:0]    gn_ff, gn_in;
   logic [7:0]        byte_ff;
   logic [7:0]        nib_byte;

   assign addr_ext = {7'd0, req_data.table_addr};
   assign cb_we = cmd.accept && (req_data.req_type == REQ_CODEBOOK)
                  && (addr_ext < 17'(CB_DEPTH));
   assign sc_we = cmd.accept && (req_data.req_type == REQ_SCALE)
                  && (addr_ext < 17'(SCALE_DEPTH));
   assign gi_we = cmd.accept && (req_data.req_type == REQ_GROUP_IDX)
                  && (addr_ext < 17'(MAX_GROUPS));

   assign nib_byte = cmd.nib ? ((byte_ff >> NIBBLE_BITS) & NIBBLE_MASK)
                             : (byte_ff & NIBBLE_MASK);
   assign cb_raddr = nib_byte[CB_AW-1:0];

   cbgd_ram #(.WIDTH(16), .DEPTH(CB_DEPTH)) u_codebook (
      .clock   (clock),
      .wr_en   (cb_we),
      .wr_addr (addr_ext[CB_AW-1:0]),
      .wr_data (req_data.code_value),
      .rd_addr (cb_raddr),
      .rd_data (cb_rdata)
   );

   cbgd_ram #(.WIDTH(16), .DEPTH(SCALE_DEPTH)) u_scale (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (addr_ext[SAW-1:0]),
      .wr_data (req_data.scale_value),
      .rd_addr (gi_rdata[SAW-1:0]),
      .rd_data (sc_rdata)
   );

   cbgd_ram #(.WIDTH(8), .DEPTH(MAX_GROUPS)) u_group (
      .clock   (clock),
      .wr_en   (gi_we),
      .wr_addr (addr_ext[GAW-1:0]),
      .wr_data (req_data.group_scale_index),
      .rd_addr (gn_ff),
      .rd_data (gi_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_data.req_type == REQ_DATA)) begin
         byte_ff <= req_data.packed_byte;
      end
   end

   // effective register values
   logic [LIM_W-1:0] limit;
   logic [16:0]      gs_eff;
   logic [8:0]       sc_eff;
   logic             final_elem;
   logic             scale_err;

   always_comb begin
      limit = LIM_W'(element_count_ff);
      if (element_count_ff == 17'd0) limit = LIM_W'(1);
      if (limit > LIM_W'(MAX_ELEMENTS)) limit = LIM_W'(MAX_ELEMENTS);
      gs_eff = group_len_ff;
      if (group_len_ff == 17'd0) gs_eff = 17'd1;
      if (group_len_ff > 17'd65536) gs_eff = 17'd65536;
      sc_eff = scale_limit_ff;
      if (scale_limit_ff > 9'(SCALE_DEPTH)) sc_eff = 9'(SCALE_DEPTH);
   end

   // element position counters
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      pos_ff, pos_in;
   logic             aborted_ff, aborted_in;
   logic             err_ff;

   assign final_elem = (LIM_W'(cnt_ff) + LIM_W'(1)) >= limit;
   assign scale_err  = {1'b0, gi_rdata} >= sc_eff;

   always_comb begin
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      gn_in      = gn_ff;
      aborted_in = aborted_ff;
      if (cmd.emit && err_ff) aborted_in = 1'b1;
      if (cmd.advance) begin
         if (final_elem) begin
            cnt_in     = '0;
            pos_in     = '0;
            gn_in      = '0;
            aborted_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            if ({1'b0, pos_ff} + 17'd1 >= gs_eff) begin
               pos_in = '0;
               gn_in  = (17'(gn_ff) + 17'd1 >= 17'(MAX_GROUPS)) ? '0 : gn_ff + GAW'(1);
            end else begin
               pos_in = pos_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         pos_ff     <= '0;
         gn_ff      <= '0;
         aborted_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         gn_ff      <= gn_in;
         aborted_ff <= aborted_in;
      end
   end

   // two multiplier stages
   logic signed [32:0] p1_ff;
   logic signed [48:0] p2_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         p1_ff  <= 33'($signed(cb_rdata) * $signed({1'b0, sc_rdata}));
         err_ff <= scale_err;
      end
      if (cmd.mul2) begin
         p2_ff <= 49'(p1_ff * $signed({1'b0, global_scale_ff}));
      end
   end

   // round to nearest, ties up, then saturate to q8.24
   logic signed [49:0] biased;
   logic signed [34:0] q;
   logic signed [31:0] sat_value;

   always_comb begin
      biased = 50'(p2_ff) + 50'sd16384;
      q      = 35'(biased >>> 15);
      if (q > 35'sd2147483647)       sat_value = 32'sh7fffffff;
      else if (q < -35'sd2147483648) sat_value = 32'sh80000000;
      else                           sat_value = q[31:0];
   end

   // output register
   logic                          rsp_valid_ff;
   rsp_payload_type               rsp_data_ff;
   logic [CNT_W+15:0]             idx_wide;
   logic                          out_free;

   assign idx_wide = (CNT_W + 16)'(cnt_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.value         <= err_ff ? 32'sd0 : sat_value;
         rsp_data_ff.element_index <= idx_wide[15:0];
         rsp_data_ff.scale_error   <= err_ff;
         rsp_data_ff.last          <= final_elem || err_ff || cmd.nib;
         rsp_data_ff.tensor_done   <= final_elem;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.is_data    = (req_data.req_type == REQ_DATA);
   assign status.aborted    = aborted_ff;
   assign status.final_elem = final_elem;
   assign status.out_free   = out_free;

   `CBGD_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, out_free, "emit into a full output register")
   `CBGD_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff, "emitted result not presented")
   `CBGD_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid_ff && rsp_data_ff.scale_error, rsp_data_ff.value == 32'sd0 && rsp_data_ff.last, "error result malformed")
   `CBGD_ASSERT_NEXT(a_err_aborts, clock, reset, cmd.emit && err_ff && !final_elem, aborted_ff, "scale error did not abort tensor")
endmodule

// File: hdl/codebook_4bit_group_dequantizer.sv
// top level of the grouped 4-bit codebook dequantizer
//
// request transactions either load a table (codebook, scale table, per-group scale
// index) or carry one byte of two 4-bit codebook indices, low nibble first. each
// element gives codebook * scale_table[group index] * global scale in signed q8.24,
// rounded to nearest (ties up) and saturated. the group is tracked by counting
// elements within the group. a group index not below the scale count register gives
// one result with scale_error set and value 0; the rest of that tensor is counted
// but dropped.
// sequence: a table write is taken in idle. a data byte is handled as two elements:
// each element walks a group index memory read, a scale and codebook memory read
// and two registered multiplier stages, then emits its result; the sequencer goes
// back to idle before the next request transaction. a dropped element skips both.
// a finished result waits in the output register while the next transaction is
// taken, but a further result waits for that register to drain. there is no
// clearing pass after reset; unwritten table entries read as undefined.
`timescale 1ns / 1ps
module codebook_4bit_group_dequantizer #(
   parameter int SCALE_DEPTH  = 256,
   parameter int MAX_GROUPS   = 1024,
   parameter int MAX_ELEMENTS = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   // register write port
   input  logic                      csr_write,
   input  logic [1:0]                csr_addr,
   input  logic [16:0]               csr_wdata,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cbgd_pkg::req_payload_type req_data,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cbgd_pkg::rsp_payload_type rsp_data
);
   import cbgd_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: one transaction at a time, one element at a time
   cbgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, counters, arithmetic and the output register
   cbgd_datapath #(
      .SCALE_DEPTH  (SCALE_DEPTH),
      .MAX_GROUPS   (MAX_GROUPS),
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
